// ===== sv/stw_pkg.sv =====
// ----------------------------------------------------------------------------
// stw_pkg: shared types and constants of the strided tensor address walker
// Widths, dimension count, register indexes and the pipeline side band.
// ----------------------------------------------------------------------------
package stw_pkg;

    // Dimension count; only the innermost MAX_DIMS dimensions are walked
    localparam int NUM_DIMS     = 4;
    localparam int MAX_DIMS     = 4;
    localparam int FIRST_ACTIVE = NUM_DIMS - MAX_DIMS;

    localparam int EXT_W    = 12;
    localparam int STRIDE_W = 24;
    localparam int PROD_W   = EXT_W + STRIDE_W;
    localparam int ADDR_W   = 38;
    localparam int COUNT_W  = 48;
    localparam int CFG_IDX_W = 3;

    typedef logic [EXT_W-1:0]    ext_t;
    typedef logic [STRIDE_W-1:0] stride_t;
    typedef logic [PROD_W-1:0]   prod_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [COUNT_W-1:0]  count_t;

    typedef ext_t    [NUM_DIMS-1:0] ext_vec_t;
    typedef stride_t [NUM_DIMS-1:0] stride_vec_t;
    typedef prod_t   [NUM_DIMS-1:0] prod_vec_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXTENT_0 = 3'd0,
        REG_EXTENT_1 = 3'd1,
        REG_EXTENT_2 = 3'd2,
        REG_EXTENT_3 = 3'd3,
        REG_STRIDE_0 = 3'd4,
        REG_STRIDE_1 = 3'd5,
        REG_STRIDE_2 = 3'd6,
        REG_STRIDE_3 = 3'd7
    } cfg_reg_idx_t;

    // Per-element side band that travels down the pipeline
    typedef struct packed {
        count_t number;
        logic   last;
        logic   empty;
    } elem_meta_t;

    // Walker stage output: positions to multiply plus side band
    typedef struct packed {
        logic       valid;
        ext_vec_t   pos;
        elem_meta_t meta;
    } walk_stage_t;

endpackage

// ===== sv/stw_walker.sv =====
// ----------------------------------------------------------------------------
// stw_walker: index counter of the strided walk
// Holds the per-dimension positions and the element counter, steps them once
// per accepted request and registers the positions of the emitted element.
// ----------------------------------------------------------------------------
module stw_walker
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 restart,
    input  stw_pkg::ext_vec_t    extent,
    output stw_pkg::walk_stage_t stage_out,
    input  logic                 stage_ready
);
    import stw_pkg::*;

    ext_vec_t    pos_reg;
    ext_vec_t    pos_next;
    count_t      cnt_reg;
    count_t      cnt_next;
    walk_stage_t stage_reg;
    walk_stage_t stage_next;

    ext_vec_t             pos_cur;
    ext_vec_t             pos_adv;
    count_t               cnt_cur;
    logic [NUM_DIMS-1:0]  at_end;
    logic                 empty;
    logic                 last;
    logic                 carry;
    logic                 accept;

    // Stage register takes a new request when empty or draining
    assign in_stall = stage_reg.valid && !stage_ready;
    assign accept   = in_valid && !in_stall;

    // Index step: end detection and innermost-first carry chain
    always_comb
    begin
        pos_cur = restart ? '0 : pos_reg;
        cnt_cur = restart ? '0 : cnt_reg;
        empty   = 1'b0;
        last    = 1'b1;
        at_end  = '1;
        for (int d = FIRST_ACTIVE; d < NUM_DIMS; d++)
        begin
            if (extent[d] == '0)
            begin
                empty = 1'b1;
            end
            at_end[d] = ({1'b0, pos_cur[d]} + (EXT_W+1)'(1)) >= {1'b0, extent[d]};
            if (!at_end[d])
            begin
                last = 1'b0;
            end
        end

        pos_adv = pos_cur;
        carry   = 1'b1;
        for (int d = NUM_DIMS - 1; d >= FIRST_ACTIVE; d--)
        begin
            if (carry)
            begin
                if (!at_end[d])
                begin
                    pos_adv[d] = pos_cur[d] + EXT_W'(1);
                    carry      = 1'b0;
                end
                else
                begin
                    pos_adv[d] = '0;
                end
            end
        end

        pos_next = empty ? '0 : pos_adv;
        cnt_next = (empty || last) ? '0 : cnt_cur + COUNT_W'(1);

        stage_next.valid       = 1'b1;
        stage_next.pos         = empty ? '0 : pos_cur;
        stage_next.meta.number = empty ? '0 : cnt_cur;
        stage_next.meta.last   = empty || last;
        stage_next.meta.empty  = empty;
    end

    // Walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            cnt_reg <= cnt_next;
        end
    end

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (accept)
        begin
            stage_reg <= stage_next;
        end
        else if (stage_ready)
        begin
            stage_reg.valid <= 1'b0;
        end
    end

    assign stage_out = stage_reg;

    // Empty view always reports element zero as the last one
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg.valid && stage_reg.meta.empty)
            |-> (stage_reg.meta.last && stage_reg.meta.number == '0))
        else $error("empty view element not flagged last at number zero");

    // Counter restarts after the final element
    a_last_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (empty || last)) |=> (cnt_reg == '0))
        else $error("element counter not cleared after last element");

    // Counter steps one past the emitted number it was taken from
    a_number_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !empty && !last) |=> (cnt_reg == stage_reg.meta.number + COUNT_W'(1)))
        else $error("element counter did not advance by one");

endmodule

// ===== sv/stw_addr_pipe.sv =====
// ----------------------------------------------------------------------------
// stw_addr_pipe: offset arithmetic of the strided walk
// Multiplies each position by its stride, adds the products in two levels and
// holds the finished result in the output register.
// ----------------------------------------------------------------------------
module stw_addr_pipe
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  stw_pkg::walk_stage_t stage_in,
    output logic                 stage_ready,
    input  stw_pkg::stride_vec_t stride,
    output logic                 out_valid,
    input  logic                 out_stall,
    output stw_pkg::addr_t       element_address,
    output stw_pkg::count_t      element_number,
    output logic                 last_element,
    output logic                 empty_view
);
    import stw_pkg::*;

    localparam int PAIR_W = PROD_W + 1;

    // Product stage
    logic        prod_valid_reg;
    prod_vec_t   prod_reg;
    elem_meta_t  prod_meta_reg;
    prod_vec_t   prod_next;
    logic        prod_ready;

    // Pair sum stage
    logic              pair_valid_reg;
    logic [PAIR_W-1:0] sum_lo_reg;
    logic [PAIR_W-1:0] sum_hi_reg;
    elem_meta_t        pair_meta_reg;
    logic              pair_ready;

    // Output stage
    logic        out_valid_reg;
    addr_t       addr_reg;
    addr_t       addr_next;
    elem_meta_t  out_meta_reg;
    logic        out_ready;

    assign out_ready   = !out_valid_reg || !out_stall;
    assign pair_ready  = !pair_valid_reg || out_ready;
    assign prod_ready  = !prod_valid_reg || pair_ready;
    assign stage_ready = prod_ready;

    // One multiplier per active dimension
    always_comb
    begin
        prod_next = '0;
        for (int d = FIRST_ACTIVE; d < NUM_DIMS; d++)
        begin
            prod_next[d] = PROD_W'(stage_in.pos[d]) * PROD_W'(stride[d]);
        end
    end

    assign addr_next = ADDR_W'(({1'b0, sum_lo_reg}) + ({1'b0, sum_hi_reg}));

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            pair_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_ready)
            begin
                prod_valid_reg <= stage_in.valid;
            end
            if (pair_ready)
            begin
                pair_valid_reg <= prod_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= pair_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (prod_ready && stage_in.valid)
        begin
            prod_reg      <= prod_next;
            prod_meta_reg <= stage_in.meta;
        end
        if (pair_ready && prod_valid_reg)
        begin
            sum_lo_reg    <= PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
            sum_hi_reg    <= PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
            pair_meta_reg <= prod_meta_reg;
        end
        if (out_ready && pair_valid_reg)
        begin
            addr_reg     <= addr_next;
            out_meta_reg <= pair_meta_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign element_address = addr_reg;
    assign element_number  = out_meta_reg.number;
    assign last_element    = out_meta_reg.last;
    assign empty_view      = out_meta_reg.empty;

    // An empty view carries zero positions, so its offset is zero
    a_empty_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_meta_reg.empty) |-> (addr_reg == '0))
        else $error("empty view result with nonzero address");

    // A held result blocks the pair stage from losing its element
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && pair_valid_reg) |=> pair_valid_reg)
        else $error("pair stage dropped an element under stall");

endmodule

// ===== sv/strided_tensor_address_walker.sv =====
// ----------------------------------------------------------------------------
// strided_tensor_address_walker: element offsets of a strided 4-D view
// Top level: configuration registers, index walker and offset pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / restart): each request yields the
//   offset of the next element in row-major order; restart=1 jumps back to
//   element zero first. Output channel (out_valid / out_stall) gives the
//   source offset, the element number, a last flag and an empty-view flag.
//   Registers extent_0..3 and stride_0..3 are written through cfg_we,
//   cfg_index and cfg_wdata while no request is in flight.
//   Pipeline: the walker stage loads when a request is accepted; the
//   multiply stage, the pair add stage and the final add to the output
//   register follow in that order, each registered.
//   Throughput: one request per cycle while in_stall is low; the walker
//   updates its positions once for each accepted request.
//   Reset: extents go to 1 and strides to 0 (one scalar element at offset
//   0); the walk starts at element zero and the pipeline is empty.
//   Stall: a stalled result holds; the stages behind it keep filling and
//   in_stall rises only when all four stages are occupied.
// ----------------------------------------------------------------------------
module strided_tensor_address_walker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [stw_pkg::ADDR_W-1:0]          element_address,
    output logic [stw_pkg::COUNT_W-1:0]         element_number,
    output logic                                last_element,
    output logic                                empty_view,
    input  logic                                cfg_we,
    input  logic [stw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [stw_pkg::STRIDE_W-1:0]        cfg_wdata
);
    import stw_pkg::*;

    ext_vec_t    extent_reg;
    stride_vec_t stride_reg;
    walk_stage_t walk_stage;
    logic        walk_ready;

    // Configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                extent_reg[d] <= EXT_W'(1);
            end
            stride_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_idx_t'(cfg_index))
                REG_EXTENT_0: extent_reg[0] <= cfg_wdata[EXT_W-1:0];
                REG_EXTENT_1: extent_reg[1] <= cfg_wdata[EXT_W-1:0];
                REG_EXTENT_2: extent_reg[2] <= cfg_wdata[EXT_W-1:0];
                REG_EXTENT_3: extent_reg[3] <= cfg_wdata[EXT_W-1:0];
                REG_STRIDE_0: stride_reg[0] <= cfg_wdata;
                REG_STRIDE_1: stride_reg[1] <= cfg_wdata;
                REG_STRIDE_2: stride_reg[2] <= cfg_wdata;
                REG_STRIDE_3: stride_reg[3] <= cfg_wdata;
                default:      stride_reg    <= stride_reg;
            endcase
        end
    end

    // Index walker
    stw_walker u_walker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .restart     (restart),
        .extent      (extent_reg),
        .stage_out   (walk_stage),
        .stage_ready (walk_ready)
    );

    // Offset arithmetic and output register
    stw_addr_pipe u_addr_pipe
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .stage_in        (walk_stage),
        .stage_ready     (walk_ready),
        .stride          (stride_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .element_address (element_address),
        .element_number  (element_number),
        .last_element    (last_element),
        .empty_view      (empty_view)
    );

endmodule
